@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the operator matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmo checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define FMO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmo checker: next-cycle property failed");

`endif

@@ design/fmo_pkg.sv @@
// Package of the FM operator matrix block: constants, codes, command and payload types.
`default_nettype none

package fmo_pkg;

    localparam int OPERATORS  = 8;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 24;

    localparam logic [2:0] LAST_OP = 3'(OPERATORS - 1);

    // Word codes within one operator's row.
    localparam logic [2:0] W_RATE    = 3'd0;
    localparam logic [2:0] W_LFO     = 3'd1;
    localparam logic [2:0] W_ENV     = 3'd2;
    localparam logic [2:0] W_ENVSTEP = 3'd3;
    localparam logic [2:0] W_GAIN    = 3'd4;
    localparam logic [2:0] W_PANL    = 3'd5;
    localparam logic [2:0] W_PANR    = 3'd6;
    localparam logic [2:0] W_PHASE   = 3'd7;

    // Sine polynomial coefficients, Q8.24.
    localparam logic signed [32:0] C1_Q24 = 33'sd105414357;
    localparam logic signed [32:0] C3_Q24 = 33'sd693598668;
    localparam logic signed [32:0] C5_Q24 = 33'sd1369108894;
    localparam logic signed [32:0] C7_Q24 = 33'sd1286910780;

    localparam logic [4:0] CALC_LAST = 5'd16;
    localparam logic [4:0] READ_LAST = 5'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_PREP, S_CALC, S_MR, S_MM, S_MA, S_PR, S_PW, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        MS_NONE, MS_AA, MS_LFO_RATE, MS_A2A, MS_AC1, MS_A3A2, MS_A3C3, MS_A5A2,
        MS_A5C5, MS_A7C7, MS_ENV_GAIN, MS_EG_SIN, MS_V_RATE, MS_V_PANL, MS_V_PANR, MS_MOD
    } mul_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_A2, WB_STEP_INIT, WB_A3, WB_T1, WB_A5, WB_T3, WB_A7, WB_T5,
        WB_T7, WB_EG, WB_V, WB_MODV, WB_LEFT, WB_RIGHT, WB_STEP_ACC
    } wb_t;

    typedef struct packed {
        logic     load;
        logic     frame_clr;
        logic     word_rd;
        logic     mod_rd;
        logic     sine_prep;
        logic     env_wr;
        logic     ph_wr;
        logic [2:0] op;
        logic [2:0] tgt;
        logic [2:0] w;
        mul_sel_t mul;
        wb_t      wb;
    } fmo_cmd_t;

    typedef struct packed {
        logic              mode;
        logic [2:0]        op_index;
        logic [3:0]        word_select;
        logic signed [31:0] word_value;
    } fmo_in_t;

    typedef struct packed {
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic              saturated;
    } fmo_out_t;

endpackage

`default_nettype wire

@@ design/fmo_if.sv @@
// Valid/ready channel interfaces for the request and result sides.
`default_nettype none

interface fmo_in_if;
    import fmo_pkg::*;
    logic    valid;
    logic    ready;
    fmo_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fmo_out_if;
    import fmo_pkg::*;
    logic     valid;
    logic     ready;
    fmo_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/fmo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fmo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

@@ design/fmo_ctrl.sv @@
// Controller state machine that sequences loads and frame rendering.
`default_nettype none

module fmo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fmo_pkg::fmo_cmd_t cmd
);
    import fmo_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [2:0] tgt_reg, tgt_next;
    logic [4:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            tgt_reg   <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            tgt_reg   <= tgt_next;
            sub_reg   <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        tgt_next   = tgt_reg;
        sub_next   = sub_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_mode)
                begin
                    state_next = S_RD;
                    op_next    = '0;
                    sub_next   = '0;
                end
            end
            S_RD:
            begin
                if (sub_reg == READ_LAST)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            S_WAIT:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_CALC;
                sub_next   = '0;
            end
            S_CALC:
            begin
                if (sub_reg == CALC_LAST)
                begin
                    sub_next = '0;
                    if (op_reg == LAST_OP)
                    begin
                        state_next = S_MR;
                        op_next    = '0;
                        tgt_next   = '0;
                    end
                    else
                    begin
                        state_next = S_RD;
                        op_next    = op_reg + 3'd1;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 5'd1;
                end
            end
            S_MR:
            begin
                state_next = S_MM;
            end
            S_MM:
            begin
                state_next = S_MA;
            end
            S_MA:
            begin
                state_next = S_MR;
                if (tgt_reg == LAST_OP)
                begin
                    tgt_next = '0;
                    if (op_reg == LAST_OP)
                    begin
                        state_next = S_PR;
                        op_next    = '0;
                    end
                    else
                    begin
                        op_next = op_reg + 3'd1;
                    end
                end
                else
                begin
                    tgt_next = tgt_reg + 3'd1;
                end
            end
            S_PR:
            begin
                state_next = S_PW;
            end
            S_PW:
            begin
                if (op_reg == LAST_OP)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PR;
                    op_next    = op_reg + 3'd1;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.mul   = MS_NONE;
        cmd.wb    = WB_NONE;
        cmd.op    = op_reg;
        cmd.tgt   = (state_reg == S_MR || state_reg == S_MM || state_reg == S_MA)
                    ? tgt_reg : op_reg;
        cmd.w     = sub_reg[2:0];
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load      = in_valid && !in_mode;
                cmd.frame_clr = in_valid && in_mode;
            end
            S_RD:
            begin
                cmd.word_rd = 1'b1;
            end
            S_PREP:
            begin
                cmd.sine_prep = 1'b1;
            end
            S_CALC:
            begin
                unique case (sub_reg)
                    5'd0:    begin cmd.mul = MS_AA;                              end
                    5'd1:    begin cmd.mul = MS_LFO_RATE; cmd.wb = WB_A2;        end
                    5'd2:    begin cmd.mul = MS_A2A;      cmd.wb = WB_STEP_INIT; end
                    5'd3:    begin cmd.mul = MS_AC1;      cmd.wb = WB_A3;        end
                    5'd4:    begin cmd.mul = MS_A3A2;     cmd.wb = WB_T1;        end
                    5'd5:    begin cmd.mul = MS_A3C3;     cmd.wb = WB_A5;        end
                    5'd6:    begin cmd.mul = MS_A5A2;     cmd.wb = WB_T3;        end
                    5'd7:    begin cmd.mul = MS_A5C5;     cmd.wb = WB_A7;        end
                    5'd8:    begin cmd.mul = MS_A7C7;     cmd.wb = WB_T5;        end
                    5'd9:    begin cmd.mul = MS_ENV_GAIN; cmd.wb = WB_T7;        end
                    5'd10:   begin cmd.wb  = WB_EG;                              end
                    5'd11:   begin cmd.mul = MS_EG_SIN;                          end
                    5'd12:   begin cmd.wb  = WB_V;                               end
                    5'd13:   begin cmd.mul = MS_V_RATE;                          end
                    5'd14:   begin cmd.mul = MS_V_PANL;   cmd.wb = WB_MODV;      end
                    5'd15:   begin cmd.mul = MS_V_PANR;   cmd.wb = WB_LEFT;      end
                    5'd16:   begin cmd.wb  = WB_RIGHT;    cmd.env_wr = 1'b1;     end
                    default: begin cmd.wb  = WB_NONE;                            end
                endcase
            end
            S_MR:
            begin
                cmd.mod_rd = 1'b1;
            end
            S_MM:
            begin
                cmd.mul = MS_MOD;
            end
            S_MA:
            begin
                cmd.wb = WB_STEP_ACC;
            end
            S_PR:
            begin
                cmd.word_rd = 1'b1;
                cmd.w       = W_PHASE;
            end
            S_PW:
            begin
                cmd.ph_wr = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule

`default_nettype wire

@@ design/fmo_datapath.sv @@
// Datapath: word and matrix stores, shared multiplier, sine, envelope and mix registers.
`default_nettype none

module fmo_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  fmo_pkg::fmo_cmd_t cmd,
    input  fmo_pkg::fmo_in_t  in_data,
    output fmo_pkg::fmo_out_t out_data
);
    import fmo_pkg::*;

    localparam int SX = 32 - WORD_WIDTH;
    localparam logic signed [65:0] MQ_HI  = (66'sd1 <<< (WORD_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] MQ_LO  = -MQ_HI - 66'sd1;
    localparam logic signed [65:0] MQ_RND = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic [65:0]        M32_RND = 66'd1 << 31;
    localparam logic signed [32:0] AD_HI  = (33'sd1 <<< (WORD_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] AD_LO  = -AD_HI - 33'sd1;

    function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > AD_HI)
        begin
            return {1'b1, AD_HI[31:0]};
        end
        else if (s < AD_LO)
        begin
            return {1'b1, AD_LO[31:0]};
        end
        return {1'b0, s[31:0]};
    endfunction

    // Stores and their valid bits; an unwritten entry reads as zero.
    logic        w_we, m_we;
    logic [5:0]  w_waddr, m_waddr;
    logic [31:0] w_wdata, m_wdata;
    logic [31:0] w_rdata, m_rdata;
    logic [63:0] wv_reg, mv_reg;
    logic        wv_rd_reg, mv_rd_reg;
    logic [31:0] word_q, mod_q;

    fmo_ram #(.WIDTH(32), .DEPTH(64)) u_word_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .re(cmd.word_rd), .raddr({cmd.op, cmd.w}), .rdata(w_rdata)
    );

    fmo_ram #(.WIDTH(32), .DEPTH(64)) u_mod_ram (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .re(cmd.mod_rd), .raddr({cmd.op, cmd.tgt}), .rdata(m_rdata)
    );

    assign word_q = wv_rd_reg ? w_rdata : 32'd0;
    assign mod_q  = mv_rd_reg ? m_rdata : 32'd0;

    // Working registers.
    logic signed [31:0] w_reg [8];
    logic               pend_reg;
    logic [2:0]         pend_w_reg;
    logic [31:0]        a_reg, a2_reg, a3_reg, a5_reg, a7_reg;
    logic               neg_reg;
    logic signed [33:0] s_reg, sine_reg;
    logic signed [31:0] eg_reg, v_reg;
    logic signed [31:0] steps_reg [8];
    logic signed [31:0] modv_reg [8];
    logic signed [31:0] left_reg, right_reg;
    logic               clip_reg;
    logic signed [65:0] prod_reg;

    // Load decode.
    logic               ld_ok, ld_word, ld_mod;
    logic signed [31:0] ld_sh, ld_ext;
    logic [31:0]        ld_val;

    always_comb
    begin
        ld_ok   = cmd.load && (in_data.op_index <= LAST_OP);
        ld_word = ld_ok && !in_data.word_select[3];
        ld_mod  = ld_ok && in_data.word_select[3] && (in_data.word_select[2:0] <= LAST_OP);
        ld_sh   = in_data.word_value <<< SX;
        ld_ext  = ld_sh >>> SX;
        ld_val  = (in_data.word_select == {1'b0, W_PHASE}) ? in_data.word_value : ld_ext;
    end

    // Envelope and phase updates.
    logic [32:0] env_sum;
    logic [31:0] ph_inc, ph_new;

    always_comb
    begin
        env_sum = sat_add(w_reg[W_ENV], w_reg[W_ENVSTEP]);
        ph_inc  = 32'($unsigned(steps_reg[cmd.tgt])) << 8;
        ph_new  = word_q + ph_inc;
    end

    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = {in_data.op_index, in_data.word_select[2:0]};
        w_wdata = ld_val;
        priority if (cmd.env_wr)
        begin
            w_we    = 1'b1;
            w_waddr = {cmd.op, W_ENV};
            w_wdata = env_sum[31:0];
        end
        else if (cmd.ph_wr)
        begin
            w_we    = 1'b1;
            w_waddr = {cmd.op, W_PHASE};
            w_wdata = ph_new;
        end
        else if (ld_word)
        begin
            w_we = 1'b1;
        end
        m_we    = ld_mod;
        m_waddr = {in_data.op_index, in_data.word_select[2:0]};
        m_wdata = ld_val;
    end

    // Multiplier operand selection.
    logic signed [32:0] ma, mb;

    always_comb
    begin
        unique case (cmd.mul)
            MS_NONE:     begin ma = '0;                        mb = '0;                       end
            MS_AA:       begin ma = $signed({1'b0, a_reg});    mb = $signed({1'b0, a_reg});   end
            MS_LFO_RATE: begin ma = 33'(w_reg[W_LFO]);         mb = 33'(w_reg[W_RATE]);       end
            MS_A2A:      begin ma = $signed({1'b0, a2_reg});   mb = $signed({1'b0, a_reg});   end
            MS_AC1:      begin ma = $signed({1'b0, a_reg});    mb = C1_Q24;                   end
            MS_A3A2:     begin ma = $signed({1'b0, a3_reg});   mb = $signed({1'b0, a2_reg});  end
            MS_A3C3:     begin ma = $signed({1'b0, a3_reg});   mb = C3_Q24;                   end
            MS_A5A2:     begin ma = $signed({1'b0, a5_reg});   mb = $signed({1'b0, a2_reg});  end
            MS_A5C5:     begin ma = $signed({1'b0, a5_reg});   mb = C5_Q24;                   end
            MS_A7C7:     begin ma = $signed({1'b0, a7_reg});   mb = C7_Q24;                   end
            MS_ENV_GAIN: begin ma = 33'(w_reg[W_ENV]);         mb = 33'(w_reg[W_GAIN]);       end
            MS_EG_SIN:   begin ma = 33'(eg_reg);               mb = sine_reg[32:0];           end
            MS_V_RATE:   begin ma = 33'(v_reg);                mb = 33'(w_reg[W_RATE]);       end
            MS_V_PANL:   begin ma = 33'(v_reg);                mb = 33'(w_reg[W_PANL]);       end
            MS_V_PANR:   begin ma = 33'(v_reg);                mb = 33'(w_reg[W_PANR]);       end
            MS_MOD:      begin ma = 33'(modv_reg[cmd.op]);     mb = 33'($signed(mod_q));      end
            default:     begin ma = '0;                        mb = '0;                       end
        endcase
    end

    // Product post-processing: Q8.24 round and saturate, Q0.32 round.
    logic signed [65:0] rq;
    logic [65:0]        ru;
    logic               mq_clip;
    logic signed [31:0] mq;
    logic [31:0]        m32;

    always_comb
    begin
        rq      = (prod_reg + MQ_RND) >>> FRAC_BITS;
        mq_clip = (rq > MQ_HI) || (rq < MQ_LO);
        if (rq > MQ_HI)
        begin
            mq = MQ_HI[31:0];
        end
        else if (rq < MQ_LO)
        begin
            mq = MQ_LO[31:0];
        end
        else
        begin
            mq = rq[31:0];
        end
        ru  = $unsigned(prod_reg) + M32_RND;
        m32 = ru[63:32];
    end

    // Sine argument folding.
    logic signed [33:0] xs, xa;
    logic signed [33:0] s_fin;
    logic [32:0]        acc_l, acc_r, acc_s;

    always_comb
    begin
        if (w_reg[W_PHASE][31])
        begin
            xs = 34'sh0C0000000 - $signed({2'b00, w_reg[W_PHASE]});
        end
        else
        begin
            xs = $signed({2'b00, w_reg[W_PHASE]}) - 34'sh040000000;
        end
        xa    = xs[33] ? -xs : xs;
        s_fin = s_reg - $signed({2'b00, m32});
        acc_l = sat_add(left_reg, mq);
        acc_r = sat_add(right_reg, mq);
        acc_s = sat_add(steps_reg[cmd.tgt], mq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg    <= '0;
            mv_reg    <= '0;
            wv_rd_reg <= 1'b0;
            mv_rd_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (w_we)
            begin
                wv_reg[w_waddr] <= 1'b1;
            end
            if (m_we)
            begin
                mv_reg[m_waddr] <= 1'b1;
            end
            if (cmd.word_rd)
            begin
                wv_rd_reg <= wv_reg[{cmd.op, cmd.w}];
            end
            if (cmd.mod_rd)
            begin
                mv_rd_reg <= mv_reg[{cmd.op, cmd.tgt}];
            end
            pend_reg <= cmd.word_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(ma) * 66'(mb);
        if (cmd.word_rd)
        begin
            pend_w_reg <= cmd.w;
        end
        if (pend_reg)
        begin
            w_reg[pend_w_reg] <= word_q;
        end
        if (cmd.sine_prep)
        begin
            a_reg   <= xa[31:0];
            neg_reg <= xs[33];
        end
        if (cmd.frame_clr)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            clip_reg  <= 1'b0;
        end
        unique case (cmd.wb)
            WB_NONE: ;
            WB_A2: a2_reg <= m32;
            WB_STEP_INIT:
            begin
                steps_reg[cmd.tgt] <= mq;
                if (mq_clip) clip_reg <= 1'b1;
            end
            WB_A3: a3_reg <= m32;
            WB_T1: s_reg <= $signed({2'b00, m32});
            WB_A5: a5_reg <= m32;
            WB_T3: s_reg <= s_reg - $signed({2'b00, m32});
            WB_A7: a7_reg <= m32;
            WB_T5: s_reg <= s_reg + $signed({2'b00, m32});
            WB_T7: sine_reg <= neg_reg ? -s_fin : s_fin;
            WB_EG:
            begin
                eg_reg <= mq;
                if (mq_clip) clip_reg <= 1'b1;
            end
            WB_V:
            begin
                v_reg <= mq;
                if (mq_clip) clip_reg <= 1'b1;
            end
            WB_MODV:
            begin
                modv_reg[cmd.op] <= mq;
                if (mq_clip) clip_reg <= 1'b1;
            end
            WB_LEFT:
            begin
                left_reg <= acc_l[31:0];
                if (mq_clip || acc_l[32]) clip_reg <= 1'b1;
            end
            WB_RIGHT:
            begin
                // The envelope write shares this step, so its clip is folded in here.
                right_reg <= acc_r[31:0];
                if (mq_clip || acc_r[32] || (cmd.env_wr && env_sum[32])) clip_reg <= 1'b1;
            end
            WB_STEP_ACC:
            begin
                steps_reg[cmd.tgt] <= acc_s[31:0];
                if (mq_clip || acc_s[32]) clip_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_data.left_sample  = left_reg;
    assign out_data.right_sample = right_reg;
    assign out_data.saturated    = clip_reg;
endmodule

`default_nettype wire

@@ design/fm_operator_matrix_frame.sv @@
// Top level of the eight-operator FM voice: one stereo frame per render request.
//
//  Channel   Direction  Payload                                   Handshake
//  req_in    in         mode, op_index, word_select, word_value   valid/ready
//  res_out   out        left_sample, right_sample, saturated      valid/ready
//
// A load request is written into its store and produces no result.
// A render request is worked through in order (N operators, eight here): per
// operator eight word reads, a wait and a sine setup state and seventeen steps
// on the one shared 33x33 multiplier, then a read, a multiply and an accumulate
// state per matrix coefficient through the coefficient store's read port,
// then a read and a write of each phase on the word store's ports.
// Reset clears the controller and the valid bits of both stores, so every
// word reads as zero until it is written. The block takes no request while a
// frame is in work or while its result waits on res_out.ready.
`default_nettype none

module fm_operator_matrix_frame (
    input  logic      clk,
    input  logic      rst_n,
    fmo_in_if.sink    req_in,
    fmo_out_if.source res_out
);
    import fmo_pkg::*;

    fmo_cmd_t cmd;

    // The controller owns both handshakes; the datapath sees only commands and the request payload.
    fmo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_in.valid),
        .in_mode   (req_in.data.mode),
        .in_ready  (req_in.ready),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .cmd       (cmd)
    );

    // The result registers hold their values from the last step of a frame
    // until the next render request clears them, so a stalled result is stable.
    fmo_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (req_in.data),
        .out_data (res_out.data)
    );
endmodule

`default_nettype wire

@@ design/fmo_checker.sv @@
// Port-level checker of the FM operator matrix block and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module fmo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] left_sample,
    input logic [31:0] right_sample,
    input logic        saturated
);
    // A waiting result keeps its values.
    `FMO_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(left_sample) && $stable(right_sample) && $stable(saturated))
    // No request is taken while a result waits.
    `FMO_ASSERT_SAME(a_busy_on_result, clk, rst_n, out_valid, !in_ready)
    // A load request is not directly followed by a result.
    `FMO_ASSERT_NEXT(a_load_quiet, clk, rst_n, in_valid && in_ready && !in_mode, !out_valid)
    // A render request blocks the input and gives no result in the next cycle.
    `FMO_ASSERT_NEXT(a_render_busy, clk, rst_n, in_valid && in_ready && in_mode, !in_ready && !out_valid)
endmodule

bind fm_operator_matrix_frame fmo_checker u_fmo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req_in.valid),
    .in_ready     (req_in.ready),
    .in_mode      (req_in.data.mode),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .left_sample  (res_out.data.left_sample),
    .right_sample (res_out.data.right_sample),
    .saturated    (res_out.data.saturated)
);

`default_nettype wire
